FILE: rtl/utar_pkg.sv
`default_nettype none

package utar_pkg;

    // Number of value bits converted
    localparam int VALUE_WIDTH = 32;
    // Width of the value field on the port
    localparam int IN_VALUE_W = 32;
    // Digit cells: enough for octal, which always needs the most digits
    localparam int NDIG = (VALUE_WIDTH + 2) / 3;
    // Counter covers VALUE_WIDTH-1 and NDIG-1
    localparam int CNT_W = $clog2(VALUE_WIDTH);

    // Radix select codes
    localparam logic [1:0] FUNC_DEC = 2'd0;
    localparam logic [1:0] FUNC_OCT = 2'd1;
    localparam logic [1:0] FUNC_HEXL = 2'd2;
    localparam logic [1:0] FUNC_HEXU = 2'd3;

    // ASCII anchors
    localparam logic [6:0] CH_ZERO = 7'h30;
    localparam logic [6:0] CH_NINE = 7'h39;
    localparam logic [6:0] CH_LA = 7'h61;
    localparam logic [6:0] CH_LF = 7'h66;
    localparam logic [6:0] CH_UA = 7'h41;
    localparam logic [6:0] CH_UF = 7'h46;

    typedef struct packed {
        logic [IN_VALUE_W-1:0] value;
        logic [1:0]            func;
    } in_t;

    typedef struct packed {
        logic [6:0] character;
        logic       last;
    } out_t;

    // Control shared by all digit cells
    typedef struct packed {
        logic       clr;
        logic       conv;
        logic       emit;
        logic [3:0] half;
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/utar_cell.sv
`default_nettype none

module utar_cell
    import utar_pkg::*;
(
    input  wire logic      clk,
    input  wire cell_ctl_t ctl,
    input  wire logic      carry_in,
    input  wire logic [3:0] shift_in,
    output logic [3:0]     digit,
    output logic           carry_out
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] reduced;

    // Doubling overflows the radix when the digit reaches half of it
    assign carry_out = (digit_reg >= ctl.half);
    assign reduced   = carry_out ? (digit_reg - ctl.half) : digit_reg;

    // Clear, double-and-add, or take the lower neighbor's digit
    always_comb
    begin
        digit_next = digit_reg;
        if (ctl.clr)
        begin
            digit_next = 4'd0;
        end
        else if (ctl.conv)
        begin
            digit_next = {reduced[2:0], carry_in};
        end
        else if (ctl.emit)
        begin
            digit_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

`default_nettype wire

FILE: rtl/unsigned_to_ascii_radix_core.sv
`default_nettype none

// Unsigned binary to ASCII digit string: decimal, octal, lower or upper hex.
// Input: pulse start with request (value, func) while busy is low; the item
// is taken at that clock edge and busy rises on the next cycle.
// Output: one character per strobe cycle, most significant digit first,
// no leading zeros, result.last set on the final character. A zero value
// gives the single character '0'. The receiver cannot stall; for each
// character, strobe is high for exactly one cycle.
// Operation: the value shifts into a row of NDIG digit cells one bit per
// cycle, then the row shifts out one digit per cycle, leading zero digits
// dropped. busy stays high until the last digit is out, so a new item is
// taken only after the previous one is finished, whatever the radix. A
// character appears on result in the cycle after its digit reaches the top
// cell.
// Reset: clears the sequencer and the strobe; the block comes up idle.

module unsigned_to_ascii_radix_core
    import utar_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire in_t  request,
    output logic      strobe,
    output out_t      result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam logic [CNT_W-1:0] CONV_END = CNT_W'(VALUE_WIDTH - 1);
    localparam logic [CNT_W-1:0] EMIT_END = CNT_W'(NDIG - 1);

    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [1:0]             func_reg, func_next;
    logic                   started_reg, started_next;
    logic                   strobe_reg, strobe_next;
    out_t                   result_reg, result_next;

    logic [63:0]            value_ext;
    logic                   accept;
    cell_ctl_t              ctl;
    logic [3:0]             digit [NDIG];
    logic                   carry [NDIG];
    logic [3:0]             top_digit;
    logic                   top_nz;
    logic [6:0]             letter;

    assign value_ext = 64'(request.value);
    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);

    // Digit row
    for (genvar i = 0; i < NDIG; i++)
    begin : g_cell
        if (i == 0)
        begin : g_low
            utar_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .carry_in  (value_reg[VALUE_WIDTH-1]),
                .shift_in  (4'd0),
                .digit     (digit[i]),
                .carry_out (carry[i])
            );
        end
        else
        begin : g_up
            utar_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .carry_in  (carry[i-1]),
                .shift_in  (digit[i-1]),
                .digit     (digit[i]),
                .carry_out (carry[i])
            );
        end
    end

    assign top_digit = digit[NDIG-1];
    assign top_nz    = (top_digit != 4'd0);
    assign letter    = (func_reg == FUNC_HEXU) ? CH_UA : CH_LA;

    // Cell control
    always_comb
    begin
        ctl.clr  = accept;
        ctl.conv = (state_reg == ST_CONV);
        ctl.emit = (state_reg == ST_EMIT);
        unique case (func_reg)
            FUNC_DEC: ctl.half = 4'd5;
            FUNC_OCT: ctl.half = 4'd4;
            default:  ctl.half = 4'd8;
        endcase
    end

    // Sequencer: load, shift value in, shift digits out
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        value_next   = value_reg;
        func_next    = func_reg;
        started_next = started_reg;
        strobe_next  = 1'b0;
        result_next  = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    value_next = value_ext[VALUE_WIDTH-1:0];
                    func_next  = request.func;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                value_next = {value_reg[VALUE_WIDTH-2:0], 1'b0};
                if (cnt_reg == CONV_END)
                begin
                    cnt_next     = '0;
                    started_next = 1'b0;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                // Drop leading zeros, but always show the units digit
                strobe_next = top_nz || started_reg || (cnt_reg == EMIT_END);
                result_next.last = (cnt_reg == EMIT_END);
                result_next.character = (top_digit < 4'd10)
                    ? (CH_ZERO + 7'(top_digit))
                    : (letter + 7'(top_digit - 4'd10));
                started_next = started_reg || top_nz;
                if (cnt_reg == EMIT_END)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload holds
    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        func_reg    <= func_next;
        started_reg <= started_next;
        result_reg  <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: rtl/utar_checker.sv
`default_nettype none

module utar_checker
    import utar_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire in_t  request,
    input wire logic strobe,
    input wire out_t result
);

    logic [6:0] ch;
    logic       ch_ok;

    assign ch    = result.character;
    assign ch_ok = ((ch >= CH_ZERO) && (ch <= CH_NINE)) ||
                   ((ch >= CH_LA) && (ch <= CH_LF)) ||
                   ((ch >= CH_UA) && (ch <= CH_UF));

    // A taken item keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted item");

    // Only digit characters leave
    a_char_ok: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ch_ok)
        else $error("strobe with a non-digit character");

    // After the final character, conversion of another item takes time
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |=> !strobe)
        else $error("strobe right after the last character");

    // Once idle, only the final character of an item may still be shown
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !busy) |-> result.last)
        else $error("non-final character while idle");

    // A new item never starts alongside an output character
    a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> !strobe)
        else $error("strobe as a new item starts");

endmodule

bind unsigned_to_ascii_radix_core utar_checker u_utar_checker (.*);

`default_nettype wire
